@@ hw/rtl/srrc_pkg.sv @@
`timescale 1ns / 1ps

package srrc_pkg;

   // CRC-16, MSB first, no augmentation, initial value zero
   localparam logic [15:0] CRC_POLY = 16'h8005;
   localparam int unsigned CRC_MSB  = 15;
   localparam int unsigned BYTE_MSB = 7;

   localparam int unsigned WINDOW_MAX_DEFAULT = 16;
   localparam int unsigned WINDOW_RESET       = 16;

   // packet descriptors held between front and back
   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   typedef struct packed {
      logic [31:0] seq_no;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [15:0] sent_crc;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] crc_value;
      logic [31:0] packet_seq;
      logic        last_of_run;
   } rsp_type;

   // one finished packet: sequence, computed CRC, CRC check outcome
   typedef struct packed {
      logic [31:0] seq_no;
      logic [15:0] crc;
      logic        good;
   } pkt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RELEASE
   } back_state_type;

endpackage

@@ hw/rtl/selective_repeat_receiver_crc.sv @@
`timescale 1ns / 1ps
// Channel   Ports                        Direction  Beat
// --------  ---------------------------  ---------  ------------------------------
// request   req_valid/req_ready/req_data in         one payload byte of a packet
// response  rsp_valid/rsp_ready/rsp_data out        one acknowledgement or release
// csr       csr_valid/csr_ready/csr_data in         window size write
//
// Front end takes one byte per cycle while the queue has room, folding it into
// the CRC in that cycle. A last byte queues a descriptor (four entries); the
// back end pops one only when idle, checks the window in the next cycle, drops
// it if out of range, else acks, then releases one per cycle unless rsp stalls.
// Reset (synchronous): CRC zero, base zero, all slots empty, window 16.
// A full queue stalls req; a stalled rsp holds the back end; the queue can fill.

module selective_repeat_receiver_crc
   import srrc_pkg::*;
#(
   parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data
);

   // descriptors front -> queue -> back
   logic    fq_valid, fq_ready;
   pkt_type fq_data;
   logic    qb_valid, qb_ready;
   pkt_type qb_data;

   // the user issues writes only while idle (unchecked); the port never stalls
   assign csr_ready = 1'b1;

   srrc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .pkt_valid (fq_valid),
      .pkt_ready (fq_ready),
      .pkt_data  (fq_data)
   );

   srrc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // window bookkeeping and result sequencing
   srrc_back #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pkt_valid (qb_valid),
      .pkt_ready (qb_ready),
      .pkt_data  (qb_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hw/rtl/srrc_front.sv @@
`timescale 1ns / 1ps

module srrc_front
   import srrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    pkt_valid,
   input  logic    pkt_ready,
   output pkt_type pkt_data
);

   logic [15:0] crc_ff, crc_in;
   logic [15:0] crc_next;
   logic        accept;

   function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      logic        top;
      r = acc;
      for (int k = BYTE_MSB; k >= 0; k--) begin
         top = r[CRC_MSB];
         r   = {r[CRC_MSB-1:0], b[k]};
         if (top) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   // stall every byte while the queue is full; only the last one pushes
   assign req_ready = pkt_ready;
   assign accept    = req_valid && req_ready;
   assign crc_next  = crc_byte(crc_ff, req_data.data_byte);

   assign pkt_valid       = accept && req_data.last_byte;
   assign pkt_data.seq_no = req_data.seq_no;
   assign pkt_data.crc    = crc_next;
   assign pkt_data.good   = (crc_next == req_data.sent_crc);

   always_comb begin
      crc_in = crc_ff;
      if (accept) begin
         crc_in = req_data.last_byte ? 16'h0000 : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= 16'h0000;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

@@ hw/rtl/srrc_queue.sv @@
`timescale 1ns / 1ps

module srrc_queue
   import srrc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  pkt_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output pkt_type pop_data
);

   localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

   pkt_type         mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ hw/rtl/srrc_back.sv @@
`timescale 1ns / 1ps

module srrc_back
   import srrc_pkg::*;
#(
   parameter int unsigned WINDOW_MAX = WINDOW_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       pkt_valid,
   output logic       pkt_ready,
   input  pkt_type    pkt_data,
   input  logic       csr_valid,
   input  logic [4:0] csr_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   localparam int unsigned IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int unsigned WW = $clog2(WINDOW_MAX + 1);
   localparam int unsigned WIN_INIT =
      (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

   back_state_type        state_ff, state_in;
   pkt_type               pkt_ff, pkt_in;
   logic [31:0]           base_ff, base_in;
   logic [WINDOW_MAX-1:0] slot_ff, slot_in;
   logic [WW-1:0]         win_ff, win_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  out_free;
   logic [31:0]           diff_fwd, diff_bwd;
   logic                  seq_ge_base, in_window, prev_window;
   logic [IW-1:0]         offset;
   logic                  slot0_next;
   logic [WINDOW_MAX-1:0] slot_shift;
   logic [31:0]           csr_wide;
   logic [WW-1:0]         win_new;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pkt_ready = (state_ff == ST_IDLE);

   // window test, no wrap on sequence numbers
   assign seq_ge_base = (pkt_ff.seq_no >= base_ff);
   assign diff_fwd    = pkt_ff.seq_no - base_ff;
   assign diff_bwd    = base_ff - pkt_ff.seq_no;
   assign in_window   = seq_ge_base && (diff_fwd < 32'(win_ff));
   assign prev_window = !seq_ge_base && (diff_bwd <= 32'(win_ff));
   assign offset      = diff_fwd[IW-1:0];
   assign slot0_next  = (offset == '0) ? pkt_ff.good : slot_ff[0];
   assign slot_shift  = slot_ff >> 1;

   // clamp the written window to 1..WINDOW_MAX
   assign csr_wide = 32'(csr_data);
   always_comb begin
      if (csr_wide == 32'd0) begin
         win_new = WW'(1);
      end else if (csr_wide > 32'(WINDOW_MAX)) begin
         win_new = WW'(WINDOW_MAX);
      end else begin
         win_new = WW'(csr_wide);
      end
   end

   always_comb begin
      state_in     = state_ff;
      pkt_in       = pkt_ff;
      base_in      = base_ff;
      slot_in      = slot_ff;
      win_in       = win_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pkt_valid) begin
               pkt_in   = pkt_data;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!in_window && !prev_window) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.kind      = KIND_ACK;
               rsp_data_in.crc_value = pkt_ff.crc;
               rsp_data_in.packet_seq = pkt_ff.seq_no;
               if (in_window) begin
                  slot_in[offset]         = pkt_ff.good;
                  rsp_data_in.last_of_run = !slot0_next;
                  state_in                = slot0_next ? ST_RELEASE : ST_IDLE;
               end else begin
                  rsp_data_in.last_of_run = 1'b1;
                  state_in                = ST_IDLE;
               end
            end
         end
         ST_RELEASE: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.kind        = KIND_RELEASE;
               rsp_data_in.crc_value   = 16'h0000;
               rsp_data_in.packet_seq  = base_ff;
               rsp_data_in.last_of_run = !slot_shift[0];
               slot_in                 = slot_shift;
               base_in                 = base_ff + 32'd1;
               if (!slot_shift[0]) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // user writes only while idle, unchecked; slots >= win_new clear
      if (csr_valid) begin
         win_in = win_new;
         for (int i = 0; i < WINDOW_MAX; i++) begin
            if (32'(i) >= 32'(win_new)) begin
               slot_in[i] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff      <= pkt_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= 32'd0;
         slot_ff      <= '0;
         win_ff       <= WW'(WIN_INIT);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         slot_ff      <= slot_in;
         win_ff       <= win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ bench/selective_repeat_receiver_crc_tb.sv @@
`timescale 1ns / 1ps

module selective_repeat_receiver_crc_tb;
   import srrc_pkg::*;

   localparam int unsigned SLOTS         = 16;
   localparam int unsigned MAX_PAYLOAD   = 4;    // bytes per packet, kept short
   localparam int unsigned MAX_IDLE      = 18;
   localparam int unsigned SETTLE_CYCLES = 64;   // four queued drops plus back end, with margin
   localparam int unsigned LONG_HOLD     = 400;  // long enough to fill the descriptor queue
   localparam int unsigned RANDOM_BYTES  = 130;

   // one request beat waiting in the driver queue, with its lead-in idle count
   typedef struct {
      req_type     beat;
      int unsigned gap;
   } offered_beat_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [4:0] csr_data  = '0;

   // handshakes seen at the last rising edge, read by the falling-edge drivers
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   logic csr_fire = 1'b0;

   offered_beat_type queued_bytes[$];
   rsp_type          due_replies[$];
   int unsigned      failures = 0;

   // receiver mirror: running CRC, base, good slots, effective window
   logic [15:0]      rx_crc;
   logic [31:0]      rx_base;
   logic [SLOTS-1:0] rx_good;
   int unsigned      rx_window;

   // pacing
   bit          fast_phase        = 1'b0;  // no idling on either side
   bit          rsp_hold_request  = 1'b0;
   int unsigned rsp_hold_left     = 0;
   int unsigned rsp_wait          = 0;
   int unsigned req_wait          = 0;
   bit          req_armed         = 1'b0;

   selective_repeat_receiver_crc #(
      .WINDOW_MAX(SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------
   // Receiver mirror
   // ---------------------------------------------------------------

   // bitwise MSB-first CRC-16: data bit shifts in at bit 0, poly on carry-out
   function automatic logic [15:0] crc16_fold(logic [15:0] acc, logic [7:0] data);
      int   k;
      logic carry;
      for (k = BYTE_MSB; k >= 0; k--) begin
         carry = acc[CRC_MSB];
         acc   = {acc[CRC_MSB-1:0], data[k]};
         if (carry) acc = acc ^ CRC_POLY;
      end
      return acc;
   endfunction

   function automatic rsp_type make_reply(logic kind, logic [15:0] crc, logic [31:0] seq);
      rsp_type r;
      r             = '0;
      r.kind        = kind;
      r.crc_value   = crc;
      r.packet_seq  = seq;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   // window write: 0 reads as 1, anything over the slot count as the slot count;
   // slots at or beyond the new window are emptied
   task automatic apply_window(input logic [4:0] value);
      int unsigned w;
      int unsigned i;
      w = value;
      if (w < 1) w = 1;
      if (w > SLOTS) w = SLOTS;
      rx_window = w;
      for (i = w; i < SLOTS; i++) rx_good[i] = 1'b0;
   endtask

   // one accepted request beat: fold CRC, and on the last byte work out the ack
   // and any in-order releases
   task automatic predict_receive(input req_type b);
      rsp_type     run[$];
      logic [15:0] crc;
      logic [31:0] off;
      rx_crc = crc16_fold(rx_crc, b.data_byte);
      if (!b.last_byte) return;
      crc    = rx_crc;
      rx_crc = '0;
      if (b.seq_no >= rx_base && b.seq_no - rx_base < rx_window) begin
         off = b.seq_no - rx_base;
         run.push_back(make_reply(KIND_ACK, crc, b.seq_no));
         rx_good[off] = (crc == b.sent_crc);
         // slide the window over every good slot at the base
         while (rx_good[0] && run.size() < SLOTS + 1) begin
            run.push_back(make_reply(KIND_RELEASE, 16'h0000, rx_base));
            rx_good = rx_good >> 1;
            rx_base = rx_base + 1;
         end
      end else if (b.seq_no < rx_base && rx_base - b.seq_no <= rx_window) begin
         // previous window: ack only
         run.push_back(make_reply(KIND_ACK, crc, b.seq_no));
      end
      if (run.size() != 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[i]) due_replies.push_back(run[i]);
   endtask

   task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      failures++;
   endtask

   task automatic check_reply(input rsp_type got);
      rsp_type want;
      if (due_replies.size() == 0) begin
         $display("%0t: no result expected, actual kind %0d crc %0h seq %0h last %0d",
                  $time, got.kind, got.crc_value, got.packet_seq, got.last_of_run);
         failures++;
         return;
      end
      want = due_replies.pop_front();
      if (got.kind !== want.kind)               flag_field("kind", want.kind, got.kind);
      if (got.crc_value !== want.crc_value)     flag_field("crc_value", want.crc_value,
                                                           got.crc_value);
      if (got.packet_seq !== want.packet_seq)   flag_field("packet_seq", want.packet_seq,
                                                           got.packet_seq);
      if (got.last_of_run !== want.last_of_run) flag_field("last_of_run", want.last_of_run,
                                                           got.last_of_run);
   endtask

   // ---------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rx_crc    = '0;
         rx_base   = '0;
         rx_good   = '0;
         rx_window = WINDOW_RESET;
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
         csr_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         rsp_fire <= rsp_valid && rsp_ready;
         csr_fire <= csr_valid && csr_ready;
         if (csr_valid && csr_ready) apply_window(csr_data);
         if (req_valid && req_ready) predict_receive(req_data);
         if (rsp_valid && rsp_ready) check_reply(rsp_data);
      end
   end

   // idle count for one beat on either side; half the beats go straight through
   function automatic int unsigned draw_idle();
      if (fast_phase) return 0;
      if ($urandom_range(0, 1)) return 0;
      return $urandom_range(0, MAX_IDLE);
   endfunction

   // ---------------------------------------------------------------
   // Request driver: falling edge, fed from queued_bytes.
   // Valid is only dropped once the current beat has gone.
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_armed = 1'b0;
      end else if (!req_valid || req_fire) begin
         if (!req_armed && queued_bytes.size() != 0) begin
            req_wait  = queued_bytes[0].gap;
            req_armed = 1'b1;
         end
         if (req_armed && req_wait == 0) begin
            req_data  <= queued_bytes[0].beat;
            req_valid <= 1'b1;
            void'(queued_bytes.pop_front());
            req_armed = 1'b0;
         end else begin
            req_valid <= 1'b0;
            if (req_armed) req_wait--;
         end
      end
   end

   // ---------------------------------------------------------------
   // Response side: falling edge. A fresh idle count after every beat taken,
   // plus the long hold-off on request, counted here.
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_hold_request) begin
            rsp_hold_left    = LONG_HOLD;
            rsp_hold_request = 1'b0;
         end
         if (rsp_fire) rsp_wait = draw_idle();
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   // queue one packet; a good one carries its true CRC, a bad one a corrupted CRC.
   // extreme_bytes gives a 00/FF payload instead of a random one.
   task automatic send_packet(input logic [31:0] seq, input int unsigned len, input bit good,
                              input bit extreme_bytes);
      logic [7:0]       payload [0:MAX_PAYLOAD-1];
      logic [15:0]      crc;
      offered_beat_type ob;
      int unsigned      i;
      crc = '0;
      for (i = 0; i < len; i++) begin
         payload[i] = extreme_bytes ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom);
         crc        = crc16_fold(crc, payload[i]);
      end
      for (i = 0; i < len; i++) begin
         ob.beat.seq_no    = seq;
         ob.beat.data_byte = payload[i];
         ob.beat.last_byte = (i == len - 1);
         // header CRC only matters on the last byte; random elsewhere
         if (i != len - 1)  ob.beat.sent_crc = 16'($urandom);
         else if (good)     ob.beat.sent_crc = crc;
         else               ob.beat.sent_crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
         ob.gap = draw_idle();
         queued_bytes.push_back(ob);
      end
   endtask

   // sender pause: everything offered has gone in and every result has come out.
   // Polled at the rising edge, where the queues and valid are stable.
   task automatic wait_idle();
      while (queued_bytes.size() != 0 || req_valid || due_replies.size() != 0)
         @(posedge clock);
      // dropped packets give no result but may still be in the back end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [4:0] value);
      wait_idle();
      @(negedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(negedge clock); while (!csr_fire);
      csr_valid <= 1'b0;
   endtask

   // one burst of well-formed traffic: the first 1..w slots from the current base in a
   // shuffled order, with repeats, damaged copies, stale and stray packets mixed in
   task automatic run_batch(inout int unsigned counted);
      logic [31:0] order [0:SLOTS-1];
      logic [31:0] base0;
      logic [31:0] tmp;
      int unsigned w, k, i, j, len;
      base0 = rx_base;
      w     = rx_window;
      k     = $urandom_range(1, w);
      for (i = 0; i < k; i++) order[i] = base0 + i;
      for (i = k - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (i = 0; i < k; i++) begin
         len = $urandom_range(1, MAX_PAYLOAD);
         send_packet(order[i], len, $urandom_range(0, 7) != 0, 1'b0);
         counted += len;
         len = $urandom_range(1, MAX_PAYLOAD);
         case ($urandom_range(0, 7))
            0: begin
               // second copy of something already sent, good or damaged
               send_packet(order[$urandom_range(0, i)], len, $urandom_range(0, 1), 1'b0);
               counted += len;
            end
            1: if (base0 >= w) begin
               // somewhere in the previous window
               send_packet(base0 - $urandom_range(1, w), len, 1'b1, 1'b0);
               counted += len;
            end
            2: begin
               send_packet($urandom, len, 1'b1, 1'b0);       // stray, dropped
               counted += len;
            end
            3: begin
               // just past either edge of the window
               if ($urandom_range(0, 1) || base0 <= w) send_packet(base0 + w, len, 1'b1, 1'b0);
               else send_packet(base0 - w - 1, len, 1'b1, 1'b0);
               counted += len;
            end
            default: ;
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------
   initial begin
      int unsigned counted;
      int unsigned batch;
      int unsigned i;
      logic [31:0] b;
      logic [4:0]  setting;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, window 16 from reset, base 0
      send_packet(32'd0, 2, 1'b1, 1'b1);          // 00 FF payload, ack then release of 0
      send_packet(32'd3, 1, 1'b1, 1'b0);          // out of order, held
      send_packet(32'd2, 1, 1'b1, 1'b0);
      send_packet(32'd3, 1, 1'b0, 1'b0);          // bad copy empties the slot again
      send_packet(32'd1, 3, 1'b1, 1'b0);          // releases 1 and 2, stops short of 3
      send_packet(32'd0, 1, 1'b1, 1'b0);          // previous window: ack only
      send_packet(32'hFFFF_FFFF, 1, 1'b1, 1'b1);  // top sequence, all-zero byte: dropped
      send_packet(32'd19, 1, 1'b1, 1'b0);         // base + 16: dropped
      send_packet(32'd18, 1, 1'b1, 1'b0);         // base + 15: top slot
      send_packet(32'd9, 1, 1'b1, 1'b0);          // slot 6

      // shrink to 4: slots 6 and 15 are lost
      write_window(5'd4);
      send_packet(32'd6, 1, 1'b1, 1'b0);          // last slot of the window
      send_packet(32'd7, 1, 1'b1, 1'b0);          // one past: dropped
      send_packet(32'd4, 2, 1'b1, 1'b0);
      send_packet(32'd5, 1, 1'b1, 1'b0);
      send_packet(32'd3, 1, 1'b1, 1'b1);          // ack 3, release 3..6
      send_packet(32'd3, 1, 1'b1, 1'b0);          // base - 4: still acked
      send_packet(32'd2, 1, 1'b1, 1'b0);          // base - 5: dropped
      send_packet(32'd9, 1, 1'b1, 1'b0);          // resend of the lost slot

      // full window in reverse, results blocked for a long stretch: the
      // descriptor queue fills and req stalls; the base beat then yields an ack
      // and sixteen releases
      write_window(5'd16);
      b          = rx_base;
      fast_phase = 1'b1;
      rsp_hold_request = 1'b1;
      for (i = SLOTS; i > 0; i--) send_packet(b + i - 1, 1, 1'b1, 1'b0);
      wait_idle();
      fast_phase = 1'b0;

      // random bursts; window rewritten every third burst, every fourth burst flat out
      counted = 0;
      batch   = 0;
      while (counted < RANDOM_BYTES) begin
         if (batch % 3 == 0) begin
            case ((batch / 3) % 8)
               0:       setting = 5'd1;
               1:       setting = 5'd0;
               2:       setting = 5'd31;
               3:       setting = 5'd17;
               4:       setting = 5'd2;
               5:       setting = 5'd8;
               6:       setting = 5'd16;
               default: setting = 5'($urandom);
            endcase
            write_window(setting);
         end else begin
            wait_idle();
         end
         fast_phase = (batch % 4 == 3);
         run_batch(counted);
         batch++;
      end
      fast_phase = 1'b0;
      wait_idle();

      if (failures == 0) begin
         $display("selective_repeat_receiver_crc_tb: clean");
      end else begin
         $display("selective_repeat_receiver_crc_tb: errors");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("selective_repeat_receiver_crc_tb: errors");
      $finish;
   end

endmodule
